FILE: rtl/jrv_pkg.sv
// Package for the journal record validator: constants, codes, types and the CRC step.
package jrv_pkg;

    localparam int unsigned IDX_W     = 7;
    localparam int unsigned CRC_W     = 32;
    localparam int unsigned VER_W     = 16;
    localparam int unsigned ERR_W     = 4;

    localparam logic [IDX_W-1:0] IDX_MAX   = 7'd127;
    localparam logic [IDX_W-1:0] LAST_IDX  = 7'd63;
    localparam logic [IDX_W-1:0] CRC_END   = 7'd60;
    localparam logic [15:0]      REC_BYTES = 16'd64;

    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hedb8_8320;
    localparam logic [CRC_W-1:0] CRC_PRESET = 32'hffff_ffff;

    // Magic word "FRJ1" in storage order
    localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h52, 8'h4a, 8'h31};

    localparam logic [VER_W-1:0] VERSION_RESET = 16'd1;

    // Header flag bits
    localparam int unsigned FLAG_MAGIC = 0;
    localparam int unsigned FLAG_RSV_A = 1;
    localparam int unsigned FLAG_RSV_B = 2;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK           = 4'd0,
        ERR_LENGTH       = 4'd1,
        ERR_MAGIC        = 4'd2,
        ERR_VERSION      = 4'd3,
        ERR_LENGTH_FIELD = 4'd4,
        ERR_CRC          = 4'd5,
        ERR_RESERVED     = 4'd6,
        ERR_STATE        = 4'd7,
        ERR_INCONSISTENT = 4'd8
    } err_code_t;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] stored_crc;
        logic [2:0]       flags;
        logic [15:0]      version_word;
        logic [15:0]      length_word;
        logic [31:0]      generation;
        logic [31:0]      floor_value;
        logic [7:0]       state_byte;
        logic [31:0]      counter;
        logic [63:0]      owner_low;
        logic [63:0]      owner_high;
    } capture_t;

    typedef struct packed {
        logic        record_valid;
        err_code_t   error_code;
        logic [31:0] generation;
        logic [31:0] floor_value;
        logic [1:0]  reservation_state;
        logic [31:0] reserved_counter;
        logic [63:0] owner_low;
        logic [63:0] owner_high;
    } result_t;

    // Capture state at the start of a record: CRC preset, every check passing
    function automatic capture_t capture_clear();
        capture_t c;
        c       = '0;
        c.crc   = CRC_PRESET;
        c.flags = 3'b111;
        return c;
    endfunction

    // One byte of the reflected CRC-32, bit by bit
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
        end
        return c;
    endfunction

endpackage

FILE: rtl/jrv_ifs.sv
// Channel interfaces of the journal record validator.
interface jrv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface jrv_result_if;
    logic        valid;
    logic        ready;
    logic        record_valid;
    logic [3:0]  error_code;
    logic [31:0] generation;
    logic [31:0] floor_value;
    logic [1:0]  reservation_state;
    logic [31:0] reserved_counter;
    logic [63:0] owner_low;
    logic [63:0] owner_high;

    modport source (output valid, output record_valid, output error_code,
                    output generation, output floor_value, output reservation_state,
                    output reserved_counter, output owner_low, output owner_high,
                    input ready);
    modport sink   (input valid, input record_valid, input error_code,
                    input generation, input floor_value, input reservation_state,
                    input reserved_counter, input owner_low, input owner_high,
                    output ready);
endinterface

interface jrv_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] expected_version;

    modport source (output valid, output expected_version, input ready);
    modport sink   (input valid, input expected_version, output ready);
endinterface

FILE: rtl/journal_record_validator.sv
// Top level of the journal record validator: input and result registers around the checks.
//
//  channel    | dir | beat carries                      | accepted when
//  -----------+-----+-----------------------------------+----------------------
//  byte_in    | in  | data_byte, last_byte              | valid & ready
//  result_out | out | record_valid, error_code, fields  | valid & ready
//  cfg        | in  | expected_version (16 bit)         | valid & ready (always ready)
//
// One byte a cycle sustained while each closing byte finds the result slot free. A byte is
// held in the input register, then updates the running CRC and capture registers; a closing
// byte instead loads the result register from the input register and clears the capture.
// Reset clears the handshake state and the capture, and sets expected_version to 1.
// A stalled result only holds back a closing byte; ordinary bytes keep flowing
// past it into the capture registers.
module journal_record_validator (
    input  logic          clk,
    input  logic          rst_n,
    jrv_byte_if.sink      byte_in,
    jrv_result_if.source  result_out,
    jrv_cfg_if.sink       cfg
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // result register
    logic              out_valid_reg;
    jrv_pkg::result_t  out_reg;

    logic [jrv_pkg::VER_W-1:0] version_reg;

    jrv_pkg::capture_t cap;
    jrv_pkg::result_t  judged;
    logic              out_free;
    logic              advance;

    // Advance the held byte unless it closes a record and the result slot is busy
    assign out_free = !out_valid_reg || result_out.ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign byte_in.ready = !in_valid_reg || advance;
    assign cfg.ready     = 1'b1;

    jrv_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cap       (cap)
    );

    jrv_judge u_judge (
        .cap              (cap),
        .data_byte        (in_byte_reg),
        .expected_version (version_reg),
        .result           (judged)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            version_reg   <= jrv_pkg::VERSION_RESET;
        end
        else
        begin
            if (byte_in.ready)
            begin
                in_valid_reg <= byte_in.valid;
            end
            if (advance && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                version_reg <= cfg.expected_version;
            end
        end
    end

    // Payload registers: load without reset
    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.last_byte;
        end
        if (advance && in_last_reg)
        begin
            out_reg <= judged;
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.record_valid      = out_reg.record_valid;
    assign result_out.error_code        = out_reg.error_code;
    assign result_out.generation        = out_reg.generation;
    assign result_out.floor_value       = out_reg.floor_value;
    assign result_out.reservation_state = out_reg.reservation_state;
    assign result_out.reserved_counter  = out_reg.reserved_counter;
    assign result_out.owner_low         = out_reg.owner_low;
    assign result_out.owner_high        = out_reg.owner_high;

endmodule

FILE: rtl/jrv_capture.sv
// Running CRC and field capture over the bytes of one record.
module jrv_capture (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output jrv_pkg::capture_t     cap
);

    jrv_pkg::capture_t cap_reg;
    jrv_pkg::capture_t cap_next;
    jrv_pkg::capture_t cap_clear;
    logic [jrv_pkg::IDX_W-1:0] idx;

    always_comb
    begin
        cap_clear = jrv_pkg::capture_clear();

        idx      = cap_reg.byte_index;
        cap_next = cap_reg;
        if (idx < jrv_pkg::CRC_END)
        begin
            cap_next.crc = jrv_pkg::crc_byte(cap_reg.crc, data_byte);
        end
        if (idx < 7'd4)
        begin
            if (data_byte != jrv_pkg::MAGIC[idx[1:0]])
            begin
                cap_next.flags[jrv_pkg::FLAG_MAGIC] = 1'b0;
            end
        end
        else if (idx < 7'd6)
        begin
            cap_next.version_word[8*idx[0] +: 8] = data_byte;
        end
        else if (idx < 7'd8)
        begin
            cap_next.length_word[8*idx[0] +: 8] = data_byte;
        end
        else if (idx < 7'd12)
        begin
            cap_next.generation[8*idx[1:0] +: 8] = data_byte;
        end
        else if (idx < 7'd16)
        begin
            cap_next.floor_value[8*idx[1:0] +: 8] = data_byte;
        end
        else if (idx == 7'd16)
        begin
            cap_next.state_byte = data_byte;
        end
        else if (idx < 7'd20)
        begin
            if (data_byte != 8'd0)
            begin
                cap_next.flags[jrv_pkg::FLAG_RSV_A] = 1'b0;
            end
        end
        else if (idx < 7'd24)
        begin
            cap_next.counter[8*idx[1:0] +: 8] = data_byte;
        end
        else if (idx < 7'd32)
        begin
            cap_next.owner_low[8*idx[2:0] +: 8] = data_byte;
        end
        else if (idx < 7'd40)
        begin
            cap_next.owner_high[8*idx[2:0] +: 8] = data_byte;
        end
        else if (idx < jrv_pkg::CRC_END)
        begin
            if (data_byte != 8'd0)
            begin
                cap_next.flags[jrv_pkg::FLAG_RSV_B] = 1'b0;
            end
        end
        else if (idx <= jrv_pkg::LAST_IDX)
        begin
            cap_next.stored_crc[8*idx[1:0] +: 8] = data_byte;
        end
        if (idx != jrv_pkg::IDX_MAX)
        begin
            cap_next.byte_index = idx + 7'd1;
        end
        // the closing byte is judged from the old state; start afresh
        if (last_byte)
        begin
            cap_next = cap_clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= jrv_pkg::capture_clear();
        end
        else if (take)
        begin
            cap_reg <= cap_next;
        end
    end

    assign cap = cap_reg;

endmodule

FILE: rtl/jrv_judge.sv
// Record checks and result fields for the closing byte.
module jrv_judge (
    input  jrv_pkg::capture_t    cap,
    input  logic [7:0]           data_byte,
    input  logic [15:0]          expected_version,
    output jrv_pkg::result_t     result
);

    logic [31:0] stored_full;
    logic        owner_zero;
    logic        consistent;
    jrv_pkg::err_code_t err;

    always_comb
    begin
        // the closing byte is the top byte of the stored CRC
        stored_full = {data_byte, cap.stored_crc[23:0]};
        owner_zero  = (cap.owner_low | cap.owner_high) == 64'd0;
        if (cap.state_byte == 8'd0)
        begin
            consistent = (cap.counter == 32'd0) && owner_zero;
        end
        else
        begin
            consistent = (cap.floor_value != 32'd0) && (cap.counter == cap.floor_value)
                         && !owner_zero;
        end

        if (cap.byte_index != jrv_pkg::LAST_IDX)
            err = jrv_pkg::ERR_LENGTH;
        else if (!cap.flags[jrv_pkg::FLAG_MAGIC])
            err = jrv_pkg::ERR_MAGIC;
        else if (cap.version_word != expected_version)
            err = jrv_pkg::ERR_VERSION;
        else if (cap.length_word != jrv_pkg::REC_BYTES)
            err = jrv_pkg::ERR_LENGTH_FIELD;
        else if (stored_full != ~cap.crc)
            err = jrv_pkg::ERR_CRC;
        else if (!(cap.flags[jrv_pkg::FLAG_RSV_A] && cap.flags[jrv_pkg::FLAG_RSV_B]))
            err = jrv_pkg::ERR_RESERVED;
        else if (cap.state_byte > 8'd2)
            err = jrv_pkg::ERR_STATE;
        else if (!consistent)
            err = jrv_pkg::ERR_INCONSISTENT;
        else
            err = jrv_pkg::ERR_OK;

        result            = '0;
        result.error_code = err;
        if (err == jrv_pkg::ERR_OK)
        begin
            result.record_valid      = 1'b1;
            result.generation        = cap.generation;
            result.floor_value       = cap.floor_value;
            result.reservation_state = cap.state_byte[1:0];
            result.reserved_counter  = cap.counter;
            result.owner_low         = cap.owner_low;
            result.owner_high        = cap.owner_high;
        end
    end

endmodule
